>>> rtl/pkvc_pkg.sv
package pkvc_pkg;

	typedef enum logic [2:0] {
		CFG_KEY_ROW_STRIDE   = 3'd0,
		CFG_VALUE_ROW_STRIDE = 3'd1,
		CFG_HEAD_COUNT       = 3'd2,
		CFG_HEAD_LENGTH      = 3'd3,
		CFG_SLOTS_PER_BLOCK  = 3'd4,
		CFG_VECTOR_GROUP     = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [16:0] key_row_stride;
		logic [16:0] value_row_stride;
		logic [6:0]  head_count;
		logic [8:0]  head_length;
		logic [8:0]  slots_per_block;
		logic [4:0]  vector_group;
	} cfg_t;

	localparam cfg_t CfgReset = '{
		key_row_stride:   17'd4096,
		value_row_stride: 17'd4096,
		head_count:       7'd32,
		head_length:      9'd128,
		slots_per_block:  9'd16,
		vector_group:     5'd8
	};

	typedef struct packed {
		logic        wvalid;
		logic [15:0] token;
		logic [19:0] slot;
		logic [13:0] elem;
		logic [31:0] kdat;
		logic [31:0] vdat;
	} item_t;

	localparam int FifoDepth = 4;
	localparam int FifoPtrBits = 2;

	localparam int SlotDivEnd = 20;
	localparam int ElemDivEnd = 14;
	localparam int GroupDivEnd = 9;
	localparam int DivStages = 23;

endpackage

>>> rtl/pkvc_front.sv
module pkvc_front import pkvc_pkg::*; #(
	parameter int DATA_BITS = 32,
	parameter int MAX_SLOTS = 1048576,
	parameter int MAX_TOKENS = 65536
) (
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [119:0] s_axis_tdata,
	input  cfg_t         cfg,
	input  logic         fifo_full,
	output logic         push,
	output item_t        push_item
);

	localparam logic [31:0] DataMask = (DATA_BITS >= 32) ? 32'hFFFF_FFFF :
		32'((64'd1 << DATA_BITS) - 64'd1);
	localparam logic [31:0] SlotLimit = 32'(MAX_SLOTS);
	localparam logic [31:0] TokenLimit = 32'(MAX_TOKENS);

	logic [15:0] token;
	logic [20:0] slot;
	logic [13:0] elem;
	logic [15:0] elem_limit;
	logic        ok;

	assign token = s_axis_tdata[15:0];
	assign slot = s_axis_tdata[36:16];
	assign elem = s_axis_tdata[50:37];
	assign elem_limit = 16'(cfg.head_count) * 16'(cfg.head_length);

	assign ok = !slot[20] && ({11'd0, slot} < SlotLimit) && ({16'd0, token} < TokenLimit)
		&& (cfg.head_length != '0) && (cfg.slots_per_block != '0)
		&& (cfg.vector_group != '0) && ({2'd0, elem} < elem_limit);

	assign s_axis_tready = !fifo_full;
	assign push = s_axis_tvalid && !fifo_full;

	always_comb begin
		push_item.wvalid = ok;
		push_item.token = token;
		push_item.slot = slot[19:0];
		push_item.elem = elem;
		push_item.kdat = s_axis_tdata[82:51] & DataMask;
		push_item.vdat = s_axis_tdata[114:83] & DataMask;
	end

endmodule

>>> rtl/pkvc_fifo.sv
module pkvc_fifo import pkvc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  empty,
	output item_t head
);

	item_t                  mem_q [FifoDepth];
	logic [FifoPtrBits-1:0] wr_q;
	logic [FifoPtrBits-1:0] rd_q;
	logic [FifoPtrBits:0]   cnt_q;
	logic                   do_pop;

	assign full = (cnt_q == (FifoPtrBits+1)'(FifoDepth));
	assign empty = (cnt_q == '0);
	assign head = mem_q[rd_q];
	assign do_pop = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (do_pop) rd_q <= rd_q + 1'b1;
			if (push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (!push && do_pop) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end

endmodule

>>> rtl/pkvc_back.sv
module pkvc_back import pkvc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  cfg_t         cfg,
	input  logic         fifo_empty,
	input  item_t        fifo_head,
	output logic         pop,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [207:0] m_axis_tdata,
	output logic [0:0]   m_axis_tuser
);

	logic        en;

	logic        pv     [DivStages];
	item_t       pi     [DivStages];
	logic [8:0]  parem  [DivStages];
	logic [19:0] paquo  [DivStages];
	logic [8:0]  pbrem  [DivStages];
	logic [13:0] pbquo  [DivStages];
	logic [4:0]  pcrem  [DivStages];
	logic [8:0]  pcquo  [DivStages];
	logic [4:0]  pdrem  [DivStages];
	logic [8:0]  pdquo  [DivStages];

	logic        vld_s  [DivStages];
	item_t       itm_s  [DivStages];
	logic [8:0]  arem_s [DivStages];
	logic [19:0] aquo_s [DivStages];
	logic [8:0]  brem_s [DivStages];
	logic [13:0] bquo_s [DivStages];
	logic [4:0]  crem_s [DivStages];
	logic [8:0]  cquo_s [DivStages];
	logic [4:0]  drem_s [DivStages];
	logic [8:0]  dquo_s [DivStages];

	logic        v_s1;
	item_t       itm_s1;
	logic [27:0] t1_s1;
	logic [14:0] kbo_s1;
	logic [13:0] spbvg_s1;
	logic [31:0] srck_s1;
	logic [31:0] srcv_s1;
	logic [8:0]  hoff_s1;
	logic [8:0]  grp_s1;
	logic [8:0]  grps_s1;
	logic [8:0]  boff_s1;

	logic        v_s2;
	item_t       itm_s2;
	logic [39:0] k2_s2;
	logic [39:0] v2_s2;
	logic [14:0] kbo_s2;
	logic [13:0] spbvg_s2;
	logic [31:0] srck_s2;
	logic [31:0] srcv_s2;
	logic [8:0]  boff_s2;

	logic        ovld_q;
	logic        wvalid_q;
	logic [31:0] srck_q;
	logic [31:0] srcv_q;
	logic [39:0] kaddr_q;
	logic [39:0] vaddr_q;
	logic [31:0] kdat_q;
	logic [31:0] vdat_q;

	assign en = !ovld_q || m_axis_tready;
	assign pop = en;

	for (genvar g = 0; g < DivStages; g++) begin : g_div
		logic [8:0]  arem_n;
		logic [19:0] aquo_n;
		logic [8:0]  brem_n;
		logic [13:0] bquo_n;
		logic [4:0]  crem_n;
		logic [8:0]  cquo_n;
		logic [4:0]  drem_n;
		logic [8:0]  dquo_n;

		if (g == 0) begin : g_src
			assign pv[g] = !fifo_empty;
			assign pi[g] = fifo_head;
			assign parem[g] = '0;
			assign paquo[g] = '0;
			assign pbrem[g] = '0;
			assign pbquo[g] = '0;
			assign pcrem[g] = '0;
			assign pcquo[g] = '0;
			assign pdrem[g] = '0;
			assign pdquo[g] = '0;
		end else begin : g_src
			assign pv[g] = vld_s[g-1];
			assign pi[g] = itm_s[g-1];
			assign parem[g] = arem_s[g-1];
			assign paquo[g] = aquo_s[g-1];
			assign pbrem[g] = brem_s[g-1];
			assign pbquo[g] = bquo_s[g-1];
			assign pcrem[g] = crem_s[g-1];
			assign pcquo[g] = cquo_s[g-1];
			assign pdrem[g] = drem_s[g-1];
			assign pdquo[g] = dquo_s[g-1];
		end

		if (g < SlotDivEnd) begin : g_a
			logic [9:0] sh;
			logic       ge;
			assign sh = {parem[g], pi[g].slot[SlotDivEnd-1-g]};
			assign ge = (sh >= {1'b0, cfg.slots_per_block});
			assign arem_n = ge ? 9'(sh - {1'b0, cfg.slots_per_block}) : sh[8:0];
			assign aquo_n = {paquo[g][18:0], ge};
		end else begin : g_a
			assign arem_n = parem[g];
			assign aquo_n = paquo[g];
		end

		if (g < ElemDivEnd) begin : g_b
			logic [9:0] sh;
			logic       ge;
			assign sh = {pbrem[g], pi[g].elem[ElemDivEnd-1-g]};
			assign ge = (sh >= {1'b0, cfg.head_length});
			assign brem_n = ge ? 9'(sh - {1'b0, cfg.head_length}) : sh[8:0];
			assign bquo_n = {pbquo[g][12:0], ge};
		end else begin : g_b
			assign brem_n = pbrem[g];
			assign bquo_n = pbquo[g];
		end

		if (g >= ElemDivEnd) begin : g_c
			logic [5:0] sh;
			logic       ge;
			assign sh = {pcrem[g], pbrem[g][DivStages-1-g]};
			assign ge = (sh >= {1'b0, cfg.vector_group});
			assign crem_n = ge ? 5'(sh - {1'b0, cfg.vector_group}) : sh[4:0];
			assign cquo_n = {pcquo[g][7:0], ge};
		end else begin : g_c
			assign crem_n = pcrem[g];
			assign cquo_n = pcquo[g];
		end

		if (g < GroupDivEnd) begin : g_d
			logic [5:0] sh;
			logic       ge;
			assign sh = {pdrem[g], cfg.head_length[GroupDivEnd-1-g]};
			assign ge = (sh >= {1'b0, cfg.vector_group});
			assign drem_n = ge ? 5'(sh - {1'b0, cfg.vector_group}) : sh[4:0];
			assign dquo_n = {pdquo[g][7:0], ge};
		end else begin : g_d
			assign drem_n = pdrem[g];
			assign dquo_n = pdquo[g];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= pv[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				itm_s[g] <= pi[g];
				arem_s[g] <= arem_n;
				aquo_s[g] <= aquo_n;
				brem_s[g] <= brem_n;
				bquo_s[g] <= bquo_n;
				crem_s[g] <= crem_n;
				cquo_s[g] <= cquo_n;
				drem_s[g] <= drem_n;
				dquo_s[g] <= dquo_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			ovld_q <= 1'b0;
		end else if (en) begin
			v_s1 <= vld_s[DivStages-1];
			v_s2 <= v_s1;
			ovld_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			itm_s1 <= itm_s[DivStages-1];
			t1_s1 <= 28'(aquo_s[DivStages-1]) * 28'(cfg.head_count)
				+ 28'(bquo_s[DivStages-1]);
			kbo_s1 <= 15'(arem_s[DivStages-1]) * 15'(cfg.vector_group)
				+ 15'(crem_s[DivStages-1]);
			spbvg_s1 <= 14'(cfg.slots_per_block) * 14'(cfg.vector_group);
			srck_s1 <= 32'(itm_s[DivStages-1].token) * 32'(cfg.key_row_stride)
				+ 32'(itm_s[DivStages-1].elem);
			srcv_s1 <= 32'(itm_s[DivStages-1].token) * 32'(cfg.value_row_stride)
				+ 32'(itm_s[DivStages-1].elem);
			hoff_s1 <= brem_s[DivStages-1];
			grp_s1 <= cquo_s[DivStages-1];
			grps_s1 <= dquo_s[DivStages-1];
			boff_s1 <= arem_s[DivStages-1];

			itm_s2 <= itm_s1;
			k2_s2 <= 40'(t1_s1) * 40'(grps_s1) + 40'(grp_s1);
			v2_s2 <= 40'(t1_s1) * 40'(cfg.head_length) + 40'(hoff_s1);
			kbo_s2 <= kbo_s1;
			spbvg_s2 <= spbvg_s1;
			srck_s2 <= srck_s1;
			srcv_s2 <= srcv_s1;
			boff_s2 <= boff_s1;

			wvalid_q <= itm_s2.wvalid;
			kdat_q <= itm_s2.kdat;
			vdat_q <= itm_s2.vdat;
			if (itm_s2.wvalid) begin
				srck_q <= srck_s2;
				srcv_q <= srcv_s2;
				kaddr_q <= k2_s2 * 40'(spbvg_s2) + 40'(kbo_s2);
				vaddr_q <= v2_s2 * 40'(cfg.slots_per_block) + 40'(boff_s2);
			end else begin
				srck_q <= '0;
				srcv_q <= '0;
				kaddr_q <= '0;
				vaddr_q <= '0;
			end
		end
	end

	assign m_axis_tvalid = ovld_q;
	assign m_axis_tuser = wvalid_q;
	assign m_axis_tdata = {vdat_q, kdat_q, vaddr_q, kaddr_q, srcv_q, srck_q};

endmodule

>>> rtl/paged_kv_cache_scatter_address_core.sv
// channel   dir  fields (low bit first)
// s_axis    in   tdata: token_index 16, slot_index 21, element_index 14,
//                key_element 32, value_element 32, zero pad 5
// m_axis    out  tdata: source_key_address 32, source_value_address 32,
//                key cache address 40, value cache address 40,
//                key_cache_data 32, value_cache_data 32; tuser: write_valid
// cfg       in   cfg_we, cfg_index, cfg_data
//
// One item per cycle sustained while the output accepts; items pass through the input queue,
// then the bit-per-stage slot, element and group dividers (23 stages), then three
// multiply stages.
// Reset clears the queue and stage valid bits and loads the register defaults.
// An output stall freezes the back pipeline; the four-entry queue keeps taking
// input until it fills.
module paged_kv_cache_scatter_address_core import pkvc_pkg::*; #(
	parameter int DATA_BITS = 32,
	parameter int MAX_SLOTS = 1048576,
	parameter int MAX_TOKENS = 65536
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [119:0] s_axis_tdata,  // token, slot, element, key, value, pad
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [207:0] m_axis_tdata,  // src key, src value, key cache, value cache, kdat, vdat
	output logic [0:0]   m_axis_tuser,  // write_valid
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [16:0]  cfg_data
);

	cfg_t  cfg_q;
	logic  push;
	item_t push_item;
	logic  fifo_full;
	logic  fifo_empty;
	logic  pop;
	item_t fifo_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CfgReset;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_KEY_ROW_STRIDE:   cfg_q.key_row_stride <= cfg_data;
				CFG_VALUE_ROW_STRIDE: cfg_q.value_row_stride <= cfg_data;
				CFG_HEAD_COUNT:       cfg_q.head_count <= cfg_data[6:0];
				CFG_HEAD_LENGTH:      cfg_q.head_length <= cfg_data[8:0];
				CFG_SLOTS_PER_BLOCK:  cfg_q.slots_per_block <= cfg_data[8:0];
				CFG_VECTOR_GROUP:     cfg_q.vector_group <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	pkvc_front #(
		.DATA_BITS(DATA_BITS),
		.MAX_SLOTS(MAX_SLOTS),
		.MAX_TOKENS(MAX_TOKENS)
	) u_front (
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.cfg(cfg_q),
		.fifo_full(fifo_full),
		.push(push),
		.push_item(push_item)
	);

	pkvc_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(push_item),
		.full(fifo_full),
		.pop(pop),
		.empty(fifo_empty),
		.head(fifo_head)
	);

	pkvc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.fifo_empty(fifo_empty),
		.fifo_head(fifo_head),
		.pop(pop),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

endmodule

>>> rtl/pkvc_checker.sv
module pkvc_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [207:0] m_axis_tdata,
	input logic [0:0]   m_axis_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output transfer dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("output payload changed while stalled");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[143:0] == 144'd0)
		else $error("addresses not cleared on dropped write");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !m_axis_tvalid)
		else $error("output valid during reset");

endmodule

bind paged_kv_cache_scatter_address_core pkvc_checker u_pkvc_checker (.*);

>>> tb/testbench.sv
module testbench import pkvc_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 26;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_SLOTS = 1048576;
	localparam int MAX_TOKENS = 65536;

	typedef struct {
		logic [15:0] token;
		logic [20:0] slot;
		logic [13:0] elem;
		logic [31:0] kdat;
		logic [31:0] vdat;
	} elem_in_t;

	typedef struct packed {
		logic        wvalid;
		logic [31:0] src_key;
		logic [31:0] src_value;
		logic [39:0] kc_addr;
		logic [39:0] vc_addr;
		logic [31:0] kdat;
		logic [31:0] vdat;
	} scatter_t;

	typedef struct {
		elem_in_t item;
		bit       typed;
		scatter_t want;
	} stim_row_t;

	logic         clk = 0;
	logic         arst_n;
	logic         s_axis_tvalid = 0;
	logic         s_axis_tready;
	logic [119:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 0;
	logic [207:0] m_axis_tdata;
	logic [0:0]   m_axis_tuser;
	logic         cfg_we = 0;
	logic [2:0]   cfg_index = '0;
	logic [16:0]  cfg_data = '0;

	paged_kv_cache_scatter_address_core dut (.*);

	always #2 clk = ~clk;

	cfg_t      cfg;
	scatter_t  pending_writes[$];
	int        errors = 0;
	int        cycles = 0;
	int        sent = 0;
	int        received = 0;
	int        valid_seen = 0;
	bit        calm = 0;
	bit        hold_off = 0;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout at %0t", $time);
			$display("** paged_kv_cache_scatter_address_core: FAILED **");
			$finish;
		end
	end

	function automatic scatter_t scatter_predict(elem_in_t it);
		scatter_t r;
		logic [63:0] slot, tok, el, blk, boff, head, hoff, grp, goff, groups, ka, va;
		logic [63:0] hc, hl, spb, vg;
		bit ok;
		slot = 64'(it.slot[19:0]);
		tok = 64'(it.token);
		el = 64'(it.elem);
		hc = 64'(cfg.head_count);
		hl = 64'(cfg.head_length);
		spb = 64'(cfg.slots_per_block);
		vg = 64'(cfg.vector_group);
		ok = !it.slot[20] && slot < 64'(MAX_SLOTS) && tok < 64'(MAX_TOKENS)
			&& hl != 0 && spb != 0 && vg != 0 && el < hc * hl;
		r = '{default: '0};
		r.wvalid = ok;
		r.kdat = it.kdat;
		r.vdat = it.vdat;
		if (ok) begin
			blk = slot / spb;
			boff = slot % spb;
			head = el / hl;
			hoff = el % hl;
			grp = hoff / vg;
			goff = hoff % vg;
			groups = hl / vg;
			ka = ((blk * hc + head) * groups + grp) * spb * vg + boff * vg + goff;
			va = ((blk * hc + head) * hl + hoff) * spb + boff;
			r.src_key = 32'(tok * 64'(cfg.key_row_stride) + el);
			r.src_value = 32'(tok * 64'(cfg.value_row_stride) + el);
			r.kc_addr = ka[39:0];
			r.vc_addr = va[39:0];
		end
		return r;
	endfunction

	task automatic write_reg(cfg_reg_t idx, logic [16:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			CFG_KEY_ROW_STRIDE:   cfg.key_row_stride = val;
			CFG_VALUE_ROW_STRIDE: cfg.value_row_stride = val;
			CFG_HEAD_COUNT:       cfg.head_count = val[6:0];
			CFG_HEAD_LENGTH:      cfg.head_length = val[8:0];
			CFG_SLOTS_PER_BLOCK:  cfg.slots_per_block = val[8:0];
			CFG_VECTOR_GROUP:     cfg.vector_group = val[4:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic drain;
		while (pending_writes.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic send_element(elem_in_t it, bit typed, scatter_t want);
		int gap;
		if (!calm && $urandom_range(0, 9) == 0) begin
			s_axis_tvalid <= 0;
			gap = $urandom_range(1, 17);
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {5'b0, it.vdat, it.kdat, it.elem, it.slot, it.token};
		pending_writes.insert(pending_writes.size(), typed ? want : scatter_predict(it));
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sent++;
	endtask

	function automatic elem_in_t random_element(bit in_range);
		elem_in_t it;
		int lim;
		it.token = 16'($urandom);
		it.kdat = $urandom;
		it.vdat = $urandom;
		lim = int'(cfg.head_count) * int'(cfg.head_length);
		if (in_range && lim > 0)
			it.elem = 14'($urandom_range(0, (lim > 16384 ? 16384 : lim) - 1));
		else
			it.elem = 14'($urandom);
		case ($urandom_range(0, 9))
			0: it.slot = 21'h1FFFFF - 21'($urandom_range(0, 1048575));
			1: it.slot = 21'($urandom_range(0, 300));
			default: it.slot = 21'($urandom_range(0, 1048575));
		endcase
		return it;
	endfunction

	always @(posedge clk) begin
		scatter_t got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got.wvalid = m_axis_tuser[0];
			{got.vdat, got.kdat, got.vc_addr, got.kc_addr, got.src_value, got.src_key}
				= m_axis_tdata;
			received++;
			if (got.wvalid) valid_seen++;
			if (pending_writes.size() == 0) begin
				$display("%0t: unexpected transfer %p", $time, got);
				errors++;
			end else begin
				want = pending_writes.pop_front();
				if (got !== want) begin
					$display("%0t: mismatch expected %p actual %p", $time, want, got);
					errors++;
				end
			end
		end
	end

	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				m_axis_tready <= 0;
				n = 0;
				while (n < 120) begin
					@(posedge clk);
					n++;
				end
				hold_off = 0;
			end
			if (!calm && $urandom_range(0, 9) == 0) begin
				m_axis_tready <= 0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
			m_axis_tready <= 1;
		end
	end

	initial begin
		stim_row_t table_rows[$];
		stim_row_t row;
		scatter_t zero_addr;
		elem_in_t it;
		arst_n <= 0;
		cfg = CfgReset;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed rows under reset defaults
		zero_addr = '{default: '0};
		row.typed = 1;
		row.item = '{16'd0, 21'd0, 14'd0, 32'h0, 32'hFFFFFFFF};
		row.want = '{1'b1, 32'd0, 32'd0, 40'd0, 40'd0, 32'h0, 32'hFFFFFFFF};
		table_rows.insert(table_rows.size(), row);
		row.item = '{16'd1, 21'd1, 14'd1, 32'h12345678, 32'h9ABCDEF0};
		row.want = '{1'b1, 32'd4097, 32'd4097, 40'd9, 40'd17, 32'h12345678, 32'h9ABCDEF0};
		table_rows.insert(table_rows.size(), row);
		row.item = '{16'd5, 21'h1FFFFF, 14'd3, 32'hA5A5A5A5, 32'h5A5A5A5A};
		row.want = zero_addr;
		row.want.kdat = 32'hA5A5A5A5;
		row.want.vdat = 32'h5A5A5A5A;
		table_rows.insert(table_rows.size(), row);
		row.item = '{16'd5, 21'h100000, 14'd3, 32'hFFFFFFFF, 32'h0};
		row.want = zero_addr;
		row.want.kdat = 32'hFFFFFFFF;
		table_rows.insert(table_rows.size(), row);
		row.item = '{16'd7, 21'd10, 14'd4096, 32'h1, 32'h2};
		row.want = zero_addr;
		row.want.kdat = 32'h1;
		row.want.vdat = 32'h2;
		table_rows.insert(table_rows.size(), row);
		row.typed = 0;
		row.item = '{16'hFFFF, 21'hFFFFF, 14'd4095, 32'hDEADBEEF, 32'hCAFEF00D};
		table_rows.insert(table_rows.size(), row);
		row.item = '{16'hFFFF, 21'hFFFFF, 14'h3FFF, 32'h0, 32'h0};
		table_rows.insert(table_rows.size(), row);
		row.item = '{16'h8000, 21'd15, 14'd4095, 32'h80000000, 32'h1};
		table_rows.insert(table_rows.size(), row);
		row.item = '{16'h00FF, 21'd16, 14'd127, 32'h7FFFFFFF, 32'h0};
		table_rows.insert(table_rows.size(), row);
		foreach (table_rows[i])
			send_element(table_rows[i].item, table_rows[i].typed, table_rows[i].want);
		s_axis_tvalid <= 0;
		drain();

		// extreme settings, then zero divisors, then minimal, maximal, odd-group and random phases
		write_reg(CFG_KEY_ROW_STRIDE, 17'h1FFFF);
		write_reg(CFG_VALUE_ROW_STRIDE, 17'd1);
		write_reg(CFG_HEAD_COUNT, 7'd64);
		write_reg(CFG_HEAD_LENGTH, 9'd256);
		write_reg(CFG_SLOTS_PER_BLOCK, 9'd256);
		write_reg(CFG_VECTOR_GROUP, 5'd16);
		for (int i = 0; i < 6; i++) begin
			it = random_element(1);
			it.slot = (i % 2) ? 21'hFFFFF : 21'd0;
			it.token = (i % 2) ? 16'hFFFF : 16'd0;
			it.elem = (i < 3) ? 14'h3FFF : 14'd0;
			send_element(it, 0, zero_addr);
		end
		s_axis_tvalid <= 0;
		drain();
		write_reg(CFG_HEAD_LENGTH, 9'd0);
		write_reg(CFG_SLOTS_PER_BLOCK, 9'd0);
		write_reg(CFG_VECTOR_GROUP, 5'd0);
		for (int i = 0; i < 4; i++)
			send_element(random_element(0), 0, zero_addr);
		s_axis_tvalid <= 0;
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin
					write_reg(CFG_KEY_ROW_STRIDE, 17'd1);
					write_reg(CFG_VALUE_ROW_STRIDE, 17'h10000);
					write_reg(CFG_HEAD_COUNT, 7'd1);
					write_reg(CFG_HEAD_LENGTH, 9'd1);
					write_reg(CFG_SLOTS_PER_BLOCK, 9'd1);
					write_reg(CFG_VECTOR_GROUP, 5'd1);
				end
				1: begin
					write_reg(CFG_HEAD_COUNT, 7'd127);
					write_reg(CFG_HEAD_LENGTH, 9'd511);
					write_reg(CFG_SLOTS_PER_BLOCK, 9'd511);
					write_reg(CFG_VECTOR_GROUP, 5'd31);
				end
				2: begin
					write_reg(CFG_HEAD_LENGTH, 9'd100);
					write_reg(CFG_VECTOR_GROUP, 5'd7);
					write_reg(CFG_HEAD_COUNT, 7'd3);
				end
				default: begin
					write_reg(CFG_KEY_ROW_STRIDE, 17'($urandom));
					write_reg(CFG_VALUE_ROW_STRIDE, 17'($urandom));
					write_reg(CFG_HEAD_COUNT, 7'($urandom_range(1, 64)));
					write_reg(CFG_HEAD_LENGTH, 9'($urandom_range(1, 256)));
					write_reg(CFG_SLOTS_PER_BLOCK, 9'($urandom_range(1, 256)));
					write_reg(CFG_VECTOR_GROUP, 5'($urandom_range(1, 16)));
				end
			endcase
			if (phase == 3) hold_off = 1;
			if (phase == 5) calm = 1;
			for (int i = 0; i < 190; i++)
				send_element(random_element($urandom_range(0, 4) != 0), 0, zero_addr);
			s_axis_tvalid <= 0;
			drain();
		end

		$display("Covered %0d input and %0d output element transfers, %0d with writes enabled,",
			sent, received, valid_seen);
		$display("over reset, extreme, zero-divisor, odd-group and random settings with backpressure.");
		if (errors == 0 && pending_writes.size() == 0) begin
			$display("** paged_kv_cache_scatter_address_core: PASSED **");
		end else begin
			$display("** paged_kv_cache_scatter_address_core: FAILED **");
		end
		$finish;
	end
endmodule
